### hw/rtl/swpt_pkg.sv
// Package for the sync and widening pulse train block.
// Types and constants that the CSR bank, the pulse engine and the top level share.
// No dependencies.
package swpt_pkg;

   localparam int CFG_W     = 24;
   localparam int CNT_W     = 6;
   localparam int PULSES_W  = 7;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SYNC,
      PH_PULSE,
      PH_GAP,
      PH_TAIL
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_PULSE,
      CSR_PULSE_STEP,
      CSR_GAP,
      CSR_PULSE_COUNT,
      CSR_EXTRA_PULSES,
      CSR_TAIL,
      CSR_SYNC
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] first_pulse_ticks;
      logic [CFG_W-1:0] pulse_step_ticks;
      logic [CFG_W-1:0] gap_ticks;
      logic [CNT_W-1:0] pulse_count;
      logic [CNT_W-1:0] extra_pulses;
      logic [CFG_W-1:0] tail_ticks;
      logic [CFG_W-1:0] sync_ticks;
   } cfg_type;

   typedef struct packed {
      logic data_level;
      logic sync_level;
      logic frame_busy;
   } result_type;

   localparam logic [CFG_W-1:0] RST_FIRST_PULSE  = CFG_W'(1200);
   localparam logic [CFG_W-1:0] RST_PULSE_STEP   = CFG_W'(50);
   localparam logic [CFG_W-1:0] RST_GAP          = CFG_W'(600);
   localparam logic [CNT_W-1:0] RST_PULSE_COUNT  = CNT_W'(10);
   localparam logic [CNT_W-1:0] RST_EXTRA_PULSES = CNT_W'(3);
   localparam logic [CFG_W-1:0] RST_TAIL         = CFG_W'(3000);
   localparam logic [CFG_W-1:0] RST_SYNC         = CFG_W'(50);

endpackage

### hw/rtl/sync_and_widening_pulse_train.sv
// Sync and widening pulse train generator, one item per timer tick.
// Accepts one tick item every clock cycle while the result is not stalled. Each result is presented
// on the rsp_ ports after its item is accepted: the item goes into the input register, and the
// frame sequencer's single-pass update then loads the result register. A stalled result holds
// the input register, which then stalls the input side. Configuration writes take effect on the
// next tick item.
module sync_and_widening_pulse_train #(
   parameter int TICK_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_enable_press,
   input  logic                              req_mode_press,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_data_level,
   output logic                              rsp_sync_level,
   output logic                              rsp_frame_busy,
   input  logic                              csr_write,
   input  logic [swpt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [swpt_pkg::CFG_W-1:0]        csr_data
);

   logic in_valid_ff, enable_ff, mode_ff;
   logic rsp_valid_ff;
   swpt_pkg::result_type rsp_ff, result;
   swpt_pkg::cfg_type cfg;
   logic advance, in_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   swpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   swpt_engine #(.TICK_BITS(TICK_BITS)) u_engine (
      .clock        (clock),
      .reset        (reset),
      .go           (advance),
      .enable_press (enable_ff),
      .mode_press   (mode_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_take) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         enable_ff <= req_enable_press;
         mode_ff   <= req_mode_press;
      end
      if (advance) rsp_ff <= result;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_level = rsp_ff.data_level;
   assign rsp_sync_level = rsp_ff.sync_level;
   assign rsp_frame_busy = rsp_ff.frame_busy;

endmodule

### hw/rtl/swpt_csr.sv
// Configuration register bank of the pulse train block.
// Plain write port, no read-back. Uses swpt_pkg.
module swpt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [swpt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [swpt_pkg::CFG_W-1:0]          csr_data,
   output swpt_pkg::cfg_type                   cfg
);

   swpt_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (swpt_pkg::csr_index_type'(csr_index))
            swpt_pkg::CSR_FIRST_PULSE:  cfg_in.first_pulse_ticks = csr_data;
            swpt_pkg::CSR_PULSE_STEP:   cfg_in.pulse_step_ticks  = csr_data;
            swpt_pkg::CSR_GAP:          cfg_in.gap_ticks         = csr_data;
            swpt_pkg::CSR_PULSE_COUNT:  cfg_in.pulse_count  = csr_data[swpt_pkg::CNT_W-1:0];
            swpt_pkg::CSR_EXTRA_PULSES: cfg_in.extra_pulses = csr_data[swpt_pkg::CNT_W-1:0];
            swpt_pkg::CSR_TAIL:         cfg_in.tail_ticks        = csr_data;
            swpt_pkg::CSR_SYNC:         cfg_in.sync_ticks        = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_pulse_ticks <= swpt_pkg::RST_FIRST_PULSE;
         cfg_ff.pulse_step_ticks  <= swpt_pkg::RST_PULSE_STEP;
         cfg_ff.gap_ticks         <= swpt_pkg::RST_GAP;
         cfg_ff.pulse_count       <= swpt_pkg::RST_PULSE_COUNT;
         cfg_ff.extra_pulses      <= swpt_pkg::RST_EXTRA_PULSES;
         cfg_ff.tail_ticks        <= swpt_pkg::RST_TAIL;
         cfg_ff.sync_ticks        <= swpt_pkg::RST_SYNC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/swpt_engine.sv
// Frame sequencer of the pulse train block: phase state and one-tick update.
// Uses swpt_pkg; configuration comes from swpt_csr.
module swpt_engine #(
   parameter int TICK_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic                  enable_press,
   input  logic                  mode_press,
   input  swpt_pkg::cfg_type     cfg,
   output swpt_pkg::result_type  result
);

   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
   // zero-length phases collapse in at most four transitions
   localparam int SETTLE_STEPS = 4;

   typedef struct packed {
      swpt_pkg::phase_type              phase;
      logic [TICK_BITS-1:0]             ticks;
      logic [TICK_BITS-1:0]             width;
      logic [swpt_pkg::PULSES_W-1:0]    pulses;
   } eng_state_type;

   eng_state_type st_ff, st_in;
   logic enabled_ff, enabled_in;
   logic mode_ff, mode_in;

   function automatic logic [TICK_BITS-1:0] clamp_cfg(input logic [swpt_pkg::CFG_W-1:0] v);
      logic [32:0] ext;
      ext = 33'(v);
      if (ext > 33'(TICK_MAX)) clamp_cfg = TICK_MAX;
      else clamp_cfg = ext[TICK_BITS-1:0];
   endfunction

   function automatic logic [TICK_BITS-1:0] sat_add(input logic [TICK_BITS-1:0] w,
                                                    input logic [swpt_pkg::CFG_W-1:0] step);
      logic [33:0] sum;
      sum = 34'(w) + 34'(step);
      if (sum > 34'(TICK_MAX)) sat_add = TICK_MAX;
      else sat_add = sum[TICK_BITS-1:0];
   endfunction

   function automatic eng_state_type enter_pulse_or_tail(input eng_state_type s,
                                                         input swpt_pkg::cfg_type c);
      eng_state_type r;
      r = s;
      if (s.pulses != '0) begin
         r.phase = swpt_pkg::PH_PULSE;
         r.ticks = s.width;
      end else begin
         r.phase = swpt_pkg::PH_TAIL;
         r.ticks = clamp_cfg(c.tail_ticks);
      end
      return r;
   endfunction

   function automatic eng_state_type settle_step(input eng_state_type s,
                                                 input swpt_pkg::cfg_type c);
      eng_state_type r;
      r = s;
      if (s.phase != swpt_pkg::PH_IDLE && s.ticks == '0) begin
         case (s.phase)
            swpt_pkg::PH_SYNC: r = enter_pulse_or_tail(s, c);
            swpt_pkg::PH_PULSE: begin
               r.phase = swpt_pkg::PH_GAP;
               r.ticks = clamp_cfg(c.gap_ticks);
            end
            swpt_pkg::PH_GAP: begin
               // zero width, zero step, zero gap: every remaining pulse vanishes
               if (s.width == '0 && c.pulse_step_ticks == '0 && c.gap_ticks == '0)
                  r.pulses = '0;
               else if (s.pulses != '0)
                  r.pulses = s.pulses - swpt_pkg::PULSES_W'(1);
               r.width = sat_add(s.width, c.pulse_step_ticks);
               r = enter_pulse_or_tail(r, c);
            end
            default: r.phase = swpt_pkg::PH_IDLE;
         endcase
      end
      return r;
   endfunction

   function automatic eng_state_type settle(input eng_state_type s,
                                            input swpt_pkg::cfg_type c);
      eng_state_type r;
      r = s;
      for (int i = 0; i < SETTLE_STEPS; i++) r = settle_step(r, c);
      return r;
   endfunction

   eng_state_type s0, s1;
   logic start;

   always_comb begin
      start      = (st_ff.phase == swpt_pkg::PH_IDLE);
      enabled_in = enabled_ff ^ (start & enable_press);
      mode_in    = mode_ff ^ (start & mode_press);
      s0 = st_ff;
      if (start && enabled_in) begin
         s0.phase  = swpt_pkg::PH_SYNC;
         s0.ticks  = clamp_cfg(cfg.sync_ticks);
         s0.width  = clamp_cfg(cfg.first_pulse_ticks);
         s0.pulses = swpt_pkg::PULSES_W'(cfg.pulse_count)
                   + swpt_pkg::PULSES_W'(mode_in ? cfg.extra_pulses : '0);
         s0 = settle(s0, cfg);
      end
      result.data_level = (s0.phase == swpt_pkg::PH_PULSE);
      result.sync_level = (s0.phase == swpt_pkg::PH_SYNC);
      result.frame_busy = (s0.phase != swpt_pkg::PH_IDLE);
      s1 = s0;
      if (s0.phase != swpt_pkg::PH_IDLE) begin
         s1.ticks = s0.ticks - TICK_BITS'(1);
         s1 = settle(s1, cfg);
      end
      st_in = s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.phase  <= swpt_pkg::PH_IDLE;
         st_ff.ticks  <= '0;
         st_ff.width  <= '0;
         st_ff.pulses <= '0;
         enabled_ff   <= 1'b0;
         mode_ff      <= 1'b0;
      end else if (go) begin
         st_ff      <= st_in;
         enabled_ff <= enabled_in;
         mode_ff    <= mode_in;
      end
   end

endmodule

### hw/rtl/swpt_checker.sv
// Port-level checks for the pulse train block, bound to the top level.
// Sees top-level ports only; no package dependency.
module swpt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_data_level,
   input logic rsp_sync_level,
   input logic rsp_frame_busy
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_level)
         && $stable(rsp_sync_level) && $stable(rsp_frame_busy))
      else $error("stalled item changed");

   a_lines_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data_level && rsp_sync_level))
      else $error("data and sync high together");

   a_busy_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data_level || rsp_sync_level) |-> rsp_frame_busy)
      else $error("line high outside a frame");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake not clear after reset");

   a_stall_only_backed: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> $past(req_valid) || $past(req_stall))
      else $error("input stalled with no item held");

endmodule

bind sync_and_widening_pulse_train swpt_checker u_swpt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_data_level (rsp_data_level),
   .rsp_sync_level (rsp_sync_level),
   .rsp_frame_busy (rsp_frame_busy)
);
